// ===== hdl/mppc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mppc_pkg
// Shared types, register indexes and reset values of the position controller.
// ---------------------------------------------------------------------------
package mppc_pkg;

  // Register map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MAX_DUTY    = 3'd0,
    REG_UPPER_LIMIT = 3'd1,
    REG_LOWER_LIMIT = 3'd2,
    REG_GAIN        = 3'd3,
    REG_RUN_ENABLE  = 3'd4,
    REG_MODE        = 3'd5,
    REG_MANUAL_DUTY = 3'd6
  } reg_idx_t;

  // Mode codes
  localparam logic MODE_MANUAL   = 1'b0;
  localparam logic MODE_POSITION = 1'b1;

  // Direction codes
  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_BWD = 1'b1;

  // Reset values
  localparam logic        [15:0] MAX_DUTY_RST    = 16'd255;
  localparam logic signed [31:0] UPPER_LIMIT_RST = 32'sd20000;
  localparam logic signed [31:0] LOWER_LIMIT_RST = -32'sd20000;
  localparam logic signed [31:0] GAIN_RST        = 32'sd0;
  localparam logic signed [17:0] MANUAL_DUTY_RST = 18'sd0;

  // Stream widths
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 72;

  typedef struct packed {
    logic        [15:0] max_duty;
    logic signed [31:0] upper_limit;
    logic signed [31:0] lower_limit;
    logic signed [31:0] gain;
    logic               run_enable;
    logic               mode;
    logic signed [17:0] manual_duty;
  } cfg_t;

endpackage

// ===== hdl/mppc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mppc_cfg_regs
// Write-only configuration register file; unknown indexes are dropped.
// ---------------------------------------------------------------------------
module mppc_cfg_regs
  import mppc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_MAX_DUTY:    cfg_nxt.max_duty    = cfg_wdata[15:0];
        REG_UPPER_LIMIT: cfg_nxt.upper_limit = $signed(cfg_wdata[31:0]);
        REG_LOWER_LIMIT: cfg_nxt.lower_limit = $signed(cfg_wdata[31:0]);
        REG_GAIN:        cfg_nxt.gain        = $signed(cfg_wdata[31:0]);
        REG_RUN_ENABLE:  cfg_nxt.run_enable  = cfg_wdata[0];
        REG_MODE:        cfg_nxt.mode        = cfg_wdata[0];
        REG_MANUAL_DUTY: cfg_nxt.manual_duty = $signed(cfg_wdata[17:0]);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_duty    <= MAX_DUTY_RST;
      cfg_r.upper_limit <= UPPER_LIMIT_RST;
      cfg_r.lower_limit <= LOWER_LIMIT_RST;
      cfg_r.gain        <= GAIN_RST;
      cfg_r.run_enable  <= 1'b0;
      cfg_r.mode        <= MODE_MANUAL;
      cfg_r.manual_duty <= MANUAL_DUTY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/motor_position_p_controller.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_position_p_controller
// Proportional position loop with PWM duty / direction, six-stage pipeline.
// ---------------------------------------------------------------------------
//
//  channel  | ports                         | payload (lsb first)
//  ---------+-------------------------------+-------------------------------
//  input    | in_tvalid/in_tready/in_tdata  | encoder_delta, encoder_position,
//           |                               | setpoint
//  result   | out_tvalid/out_tready/out_tdata | drive_duty, drive_dir,
//           |                               | speed_counts, position_now, pad
//  config   | cfg_we/cfg_addr/cfg_wdata     | register write, no read-back
//
//  Result passes through six register stages from the input accept edge;
//  one item per cycle while out_tready is high.
//  Depth is set by the 32x32 gain multiply and the 16x16 duty scale, each
//  given a stage of its own, plus limit-compare, clamp-and-subtract, abs and mode-select stages.
//  Each stage stalls only when it is full and the one after it is blocked,
//  so bubbles close up and input keeps flowing while a result waits.
//  rst_n (synchronous) empties the pipe and loads register defaults.
// ---------------------------------------------------------------------------
module motor_position_p_controller
  import mppc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: encoder_delta[15:0], encoder_position[47:16], setpoint[79:48]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: drive_duty[15:0], drive_dir[16], speed_counts[32:17],
  //            position_now[64:33], zero pad [71:65]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t cfg;

  mppc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // ---------------- valid / ready chain ----------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !v6_r || out_tready;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // ---------------- stage 1: limit compares ----------------
  logic signed [31:0] in_pos, in_tgt;
  logic signed [31:0] s1_pos_r, s1_tgt_r;
  logic        [15:0] s1_dlt_r;
  logic               s1_gt_r, s1_lt_r;

  assign in_pos = $signed(in_tdata[47:16]);
  assign in_tgt = $signed(in_tdata[79:48]);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_dlt_r <= in_tdata[15:0];
      s1_pos_r <= in_pos;
      s1_tgt_r <= in_tgt;
      s1_gt_r  <= in_tgt > cfg.upper_limit;
      s1_lt_r  <= in_tgt < cfg.lower_limit;
    end
  end

  // ---------------- stage 2: clamp and error ----------------
  // upper test wins when the limits are crossed
  logic signed [31:0] tgt_clamped;
  logic signed [32:0] s2_err_nxt, s2_err_r;
  logic signed [31:0] s2_pos_r;
  logic        [15:0] s2_dlt_r;

  always_comb begin
    priority if (s1_gt_r) begin
      tgt_clamped = cfg.upper_limit;
    end else if (s1_lt_r) begin
      tgt_clamped = cfg.lower_limit;
    end else begin
      tgt_clamped = s1_tgt_r;
    end
    s2_err_nxt = {tgt_clamped[31], tgt_clamped} - {s1_pos_r[31], s1_pos_r};
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_err_r <= s2_err_nxt;
      s2_pos_r <= s1_pos_r;
      s2_dlt_r <= s1_dlt_r;
    end
  end

  // ---------------- stage 3: magnitudes and sign ----------------
  logic [32:0] err_abs;
  logic [31:0] gain_mag;
  logic [31:0] s3_emag_r;
  logic        s3_neg_r;
  logic signed [31:0] s3_pos_r;
  logic        [15:0] s3_dlt_r;

  assign err_abs  = s2_err_r[32] ? (33'd0 - s2_err_r) : s2_err_r;
  assign gain_mag = cfg.gain[31] ? (32'd0 - cfg.gain) : cfg.gain;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_emag_r <= err_abs[31:0];   // |err| < 2^32
      s3_neg_r  <= (cfg.gain[31] ^ s2_err_r[32]) && (|cfg.gain) && (|s2_err_r);
      s3_pos_r  <= s2_pos_r;
      s3_dlt_r  <= s2_dlt_r;
    end
  end

  // ---------------- stage 4: gain multiply ----------------
  logic [63:0] s4_prod_r;
  logic        s4_neg_r;
  logic signed [31:0] s4_pos_r;
  logic        [15:0] s4_dlt_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_prod_r <= 64'(s3_emag_r) * 64'(gain_mag);
      s4_neg_r  <= s3_neg_r;
      s4_pos_r  <= s3_pos_r;
      s4_dlt_r  <= s3_dlt_r;
    end
  end

  // ---------------- stage 5: saturate, mode select ----------------
  // manual fraction: |m| saturated at 1.0 (Q1.16)
  logic [17:0] man_abs;
  logic        sel_sat, sel_neg;
  logic [15:0] sel_frac;
  logic        s5_sat_r, s5_neg_r;
  logic [15:0] s5_frac_r;
  logic signed [31:0] s5_pos_r;
  logic        [15:0] s5_dlt_r;

  assign man_abs = cfg.manual_duty[17] ? (18'd0 - cfg.manual_duty) : cfg.manual_duty;

  always_comb begin
    unique case (cfg.mode)
      MODE_MANUAL: begin
        sel_sat  = |man_abs[17:16];
        sel_frac = man_abs[15:0];
        sel_neg  = cfg.manual_duty[17];
      end
      MODE_POSITION: begin
        sel_sat  = |s4_prod_r[63:16];
        sel_frac = s4_prod_r[15:0];
        sel_neg  = s4_neg_r;
      end
      default: begin
        sel_sat  = 1'b0;
        sel_frac = 16'd0;
        sel_neg  = DIR_FWD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_sat_r  <= sel_sat;
      s5_frac_r <= sel_frac;
      s5_neg_r  <= sel_neg;
      s5_pos_r  <= s4_pos_r;
      s5_dlt_r  <= s4_dlt_r;
    end
  end

  // ---------------- stage 6: duty scale, output register ----------------
  logic [31:0] scale_prod;
  logic [15:0] duty_nxt;
  logic        dir_nxt;
  logic [15:0] s6_duty_r;
  logic        s6_dir_r;
  logic signed [31:0] s6_pos_r;
  logic        [15:0] s6_dlt_r;

  assign scale_prod = 32'(s5_frac_r) * 32'(cfg.max_duty);

  always_comb begin
    if (!cfg.run_enable) begin
      duty_nxt = 16'd0;
      dir_nxt  = DIR_FWD;
    end else begin
      duty_nxt = s5_sat_r ? cfg.max_duty : scale_prod[31:16];
      dir_nxt  = s5_neg_r ? DIR_BWD : DIR_FWD;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_duty_r <= duty_nxt;
      s6_dir_r  <= dir_nxt;
      s6_pos_r  <= s5_pos_r;
      s6_dlt_r  <= s5_dlt_r;
    end
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = {7'd0, s6_pos_r, s6_dlt_r, s6_dir_r, s6_duty_r};

endmodule

// ===== hdl/mppc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mppc_checker
// Port-level checks for the position controller, bound to the top level.
// ---------------------------------------------------------------------------
module mppc_checker
  import mppc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // an empty output stage means the whole pipe can move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked while output stage is empty");

  // pad bits above position_now stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[71:65] == 7'd0))
    else $error("nonzero pad in result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed under stall");

endmodule

bind motor_position_p_controller mppc_checker u_mppc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/motor_position_p_controller_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_position_p_controller_tb
// Self-checking bench for the proportional position controller. A directed
// table walks reset state, manual duty saturation, gain and limit extremes,
// crossed limits and the disabled case. Three random phases follow with
// different stall patterns on both streams. Every result is checked field by field
// against an in-bench predictor, with duty and direction typed in for some table rows.
// ---------------------------------------------------------------------------
module motor_position_p_controller_tb;
  import mppc_pkg::*;

  localparam int PIPE_LAT = 6;
  localparam longint Q_ONE = 64'sd65536;
  // unmapped register index, writes must be dropped
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    logic signed [15:0] delta;
    logic signed [31:0] position;
    logic signed [31:0] target;
  } tick_t;

  typedef struct {
    logic        [15:0] duty;
    logic               dir;
    logic signed [15:0] speed;
    logic signed [31:0] position;
  } drive_t;

  typedef enum {ROW_WRITE, ROW_TICK} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_ADDR_W-1:0]   idx;
    logic [31:0]             value;
    tick_t                   tick;
    bit                      typed;
    logic [15:0]             want_duty;
    logic                    want_dir;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // in_tdata: encoder_delta, encoder_position, setpoint (lsb first)
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_tdata: drive_duty, drive_dir, speed_counts, position_now, pad (lsb first)
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  motor_position_p_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  int          send_idle_pct = 14;
  int          recv_idle_pct = 86;
  int          mismatch_count = 0;
  cfg_t        ctrl_cfg;        // shadow of the register file
  drive_t      pending_drives[$];
  stim_row_t   dir_rows[$];

  // Duty / direction law for one tick under the given register settings.
  function automatic drive_t predict_drive(input cfg_t c, input tick_t t);
    drive_t r;
    longint m, tgt, err, p, mag;
    r.duty     = '0;
    r.dir      = DIR_FWD;
    r.speed    = t.delta;
    r.position = t.position;
    if (c.run_enable) begin
      if (c.mode == MODE_MANUAL) begin
        m = $signed(c.manual_duty);
        // manual fraction saturates to +-1.0
        if (m > Q_ONE) m = Q_ONE;
        else if (m < -Q_ONE) m = -Q_ONE;
        r.dir = (m < 0) ? DIR_BWD : DIR_FWD;
        mag = (m < 0) ? -m : m;
      end else begin
        tgt = $signed(t.target);
        // upper test first, so crossed limits favor upper_limit
        if (tgt > $signed(c.upper_limit)) tgt = $signed(c.upper_limit);
        else if (tgt < $signed(c.lower_limit)) tgt = $signed(c.lower_limit);
        err = tgt - longint'($signed(t.position));
        // |gain| <= 2^31, |err| < 2^32: product fits in 64 bits
        p = longint'($signed(c.gain)) * err;
        r.dir = (p < 0) ? DIR_BWD : DIR_FWD;
        mag = (p < 0) ? -p : p;
      end
      if (mag >= Q_ONE) r.duty = c.max_duty;
      else r.duty = 16'((mag * longint'(c.max_duty)) >> 16);
    end
    return r;
  endfunction

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
  endtask

  task automatic check_drive(input logic [OUT_TDATA_W-1:0] d);
    drive_t want;
    drive_t got;
    got.duty     = d[15:0];
    got.dir      = d[16];
    got.speed    = d[32:17];
    got.position = d[64:33];
    if (pending_drives.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result, expected none actual %0h", $time, d);
      return;
    end
    want = pending_drives.pop_front();
    if (got.duty !== want.duty) report_field("drive_duty", want.duty, got.duty);
    if (got.dir !== want.dir) report_field("drive_dir", want.dir, got.dir);
    if (got.speed !== want.speed) report_field("speed_counts", want.speed, got.speed);
    if (got.position !== want.position)
      report_field("position_now", want.position, got.position);
  endtask

  // Result side: check on handshake, then re-roll ready.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_drive(out_tdata);
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Drop valid and wait until every expected result is back, plus margin.
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] value);
    drain_pipe();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_DUTY:    ctrl_cfg.max_duty    = value[15:0];
      REG_UPPER_LIMIT: ctrl_cfg.upper_limit = value;
      REG_LOWER_LIMIT: ctrl_cfg.lower_limit = value;
      REG_GAIN:        ctrl_cfg.gain        = value;
      REG_RUN_ENABLE:  ctrl_cfg.run_enable  = value[0];
      REG_MODE:        ctrl_cfg.mode        = value[0];
      REG_MANUAL_DUTY: ctrl_cfg.manual_duty = value[17:0];
      default: ;
    endcase
  endtask

  // Present one item; expected duty and direction are either typed in or predicted.
  task automatic send_tick(input tick_t t, input bit typed,
                           input logic [15:0] want_duty, input logic want_dir);
    drive_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t.target, t.position, t.delta};
    do @(posedge clk); while (!in_tready);
    want = predict_drive(ctrl_cfg, t);
    if (typed) begin
      want.duty = want_duty;
      want.dir  = want_dir;
    end
    pending_drives.push_back(want);
  endtask

  function automatic void add_write(input logic [CFG_ADDR_W-1:0] idx,
                                    input logic [31:0] value);
    stim_row_t r;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.value = value;
    r.typed = 1'b0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_tick(input logic [15:0] d, input logic [31:0] p,
                                   input logic [31:0] g, input bit typed = 1'b0,
                                   input logic [15:0] wd = '0,
                                   input logic wdir = DIR_FWD);
    stim_row_t r;
    r.kind          = ROW_TICK;
    r.tick.delta    = d;
    r.tick.position = p;
    r.tick.target   = g;
    r.typed         = typed;
    r.want_duty     = wd;
    r.want_dir      = wdir;
    dir_rows.push_back(r);
  endfunction

  // 32-bit word biased toward the corners
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly targets near the position so the proportional band gets exercised.
  function automatic tick_t random_tick();
    tick_t t;
    t.delta = 16'($urandom);
    case ($urandom_range(0, 3))
      0: t.position = $urandom;
      1: t.position = 32'($urandom_range(0, 60000)) - 32'd30000;
      2: t.position = pick_word();
      default: t.position = 32'($urandom_range(0, 2000)) - 32'd1000;
    endcase
    case ($urandom_range(0, 6))
      0: t.target = $urandom;
      1: t.target = pick_word();
      2: t.target = t.position + 32'($urandom_range(0, 200)) - 32'd100;
      3: t.target = t.position + 32'($urandom_range(0, 10000)) - 32'd5000;
      4: t.target = t.position + 32'($urandom_range(0, 140000)) - 32'd70000;
      5: t.target = t.position;
      default: t.target = 32'($urandom_range(0, 50000)) - 32'd25000;
    endcase
    return t;
  endfunction

  task automatic randomize_config();
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] g;
    logic [31:0] md;
    case ($urandom_range(0, 3))
      0: write_reg(REG_MAX_DUTY, 32'd0);
      1: write_reg(REG_MAX_DUTY, 32'hFFFF);
      2: write_reg(REG_MAX_DUTY, 32'd255);
      default: write_reg(REG_MAX_DUTY, $urandom);
    endcase
    case ($urandom_range(0, 3))
      0: begin
        hi = 32'd20000;
        lo = 32'd0 - 32'd20000;
      end
      1: begin
        hi = 32'h7FFF_FFFF;
        lo = 32'h8000_0000;
      end
      2: begin
        // may cross
        hi = pick_word();
        lo = pick_word();
      end
      default: begin
        hi = 32'($urandom_range(0, 40000)) - 32'd20000;
        lo = hi - 32'($urandom_range(0, 40000));
      end
    endcase
    write_reg(REG_UPPER_LIMIT, hi);
    write_reg(REG_LOWER_LIMIT, lo);
    case ($urandom_range(0, 5))
      0: g = pick_word();
      1: g = 32'($urandom_range(0, 4096));
      2: g = 32'd0 - 32'($urandom_range(0, 4096));
      3: g = 32'h0001_0000 + 32'($urandom_range(0, 32)) - 32'd16;
      4: g = 32'($urandom_range(0, 64));
      default: g = 32'd0;
    endcase
    write_reg(REG_GAIN, g);
    write_reg(REG_RUN_ENABLE, ($urandom_range(0, 9) != 0) ? 32'd1 : 32'd0);
    write_reg(REG_MODE, ($urandom_range(0, 3) != 0) ? 32'(MODE_POSITION) : 32'(MODE_MANUAL));
    case ($urandom_range(0, 3))
      0: md = $urandom;
      1: md = 32'($urandom_range(0, 131072)) - 32'd65536;
      2: md = $urandom_range(0, 1) ? 32'h0001_0000 : 32'h0003_0000;
      default: md = 32'd0;
    endcase
    write_reg(REG_MANUAL_DUTY, md);
    if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE, $urandom);
  endtask

  // Random items in short segments, each under fresh register settings.
  task automatic run_random(input int n_items, input int s_idle, input int r_idle);
    int sent;
    int seg;
    sent = 0;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    while (sent < n_items) begin
      randomize_config();
      seg = $urandom_range(15, 45);
      for (int k = 0; k < seg && sent < n_items; k++) begin
        send_tick(random_tick(), 1'b0, '0, DIR_FWD);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    ctrl_cfg.max_duty    = MAX_DUTY_RST;
    ctrl_cfg.upper_limit = UPPER_LIMIT_RST;
    ctrl_cfg.lower_limit = LOWER_LIMIT_RST;
    ctrl_cfg.gain        = GAIN_RST;
    ctrl_cfg.run_enable  = 1'b0;
    ctrl_cfg.mode        = MODE_MANUAL;
    ctrl_cfg.manual_duty = MANUAL_DUTY_RST;

    // out of reset the motor is disabled
    add_tick(16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'd0, DIR_FWD);
    add_write(REG_RUN_ENABLE, 32'd1);
    add_tick(16'h8000, 32'h8000_0000, 32'd0, 1'b1, 16'd0, DIR_FWD);
    // manual duty: full scale both ways, then beyond full scale
    add_write(REG_MANUAL_DUTY, 32'h0001_0000);
    add_tick(16'd1, 32'd10, 32'd20, 1'b1, 16'd255, DIR_FWD);
    add_write(REG_MANUAL_DUTY, 32'h0003_0000);
    add_tick(16'd2, 32'd11, 32'd21, 1'b1, 16'd255, DIR_BWD);
    add_write(REG_MANUAL_DUTY, 32'h0001_FFFF);
    add_tick(16'd3, 32'd12, 32'd22, 1'b1, 16'd255, DIR_FWD);
    add_write(REG_MANUAL_DUTY, 32'h0002_0000);
    add_tick(16'd4, 32'd13, 32'd23, 1'b1, 16'd255, DIR_BWD);
    // tiny negative: duty truncates to zero but direction stays backward
    add_write(REG_MANUAL_DUTY, 32'hFFFF_FFFF);
    add_tick(16'd5, 32'd14, 32'd24, 1'b1, 16'd0, DIR_BWD);
    add_write(REG_MANUAL_DUTY, 32'h0000_8000);
    add_tick(16'd6, 32'd15, 32'd25);
    add_write(REG_MAX_DUTY, 32'hFFFF);
    add_write(REG_MANUAL_DUTY, 32'h0001_0000);
    add_tick(16'd7, 32'd16, 32'd26, 1'b1, 16'hFFFF, DIR_FWD);
    // write to an unmapped index must change nothing
    add_write(REG_SPARE, 32'hFFFF_FFFF);
    add_tick(16'd8, 32'd17, 32'd27);
    add_write(REG_MAX_DUTY, 32'd0);
    add_tick(16'd9, 32'd18, 32'd28, 1'b1, 16'd0, DIR_FWD);
    // position mode, zero gain
    add_write(REG_MAX_DUTY, 32'hFFFF);
    add_write(REG_MODE, 32'(MODE_POSITION));
    add_tick(16'd10, 32'd0, 32'd5000, 1'b1, 16'd0, DIR_FWD);
    // unity gain: clamp to default limits then saturate
    add_write(REG_GAIN, 32'h0001_0000);
    add_tick(16'd11, 32'd0, 32'd30000, 1'b1, 16'hFFFF, DIR_FWD);
    add_tick(16'd12, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'hFFFF, DIR_BWD);
    // smallest gain: sub-count duty, sign still drives direction
    add_write(REG_GAIN, 32'd1);
    add_tick(16'd13, 32'd1000, 32'd1001);
    add_tick(16'd14, 32'd1000, 32'd999);
    add_tick(16'd15, 32'd0, 32'd0);
    // widest limits, extreme gains, largest error
    add_write(REG_UPPER_LIMIT, 32'h7FFF_FFFF);
    add_write(REG_LOWER_LIMIT, 32'h8000_0000);
    add_write(REG_GAIN, 32'h7FFF_FFFF);
    add_tick(16'd16, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 16'hFFFF, DIR_FWD);
    add_write(REG_GAIN, 32'h8000_0000);
    add_tick(16'd17, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 16'hFFFF, DIR_BWD);
    add_tick(16'd18, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'hFFFF, DIR_FWD);
    // crossed limits: upper test wins when the target is above it
    add_write(REG_UPPER_LIMIT, 32'hFFFF_FF9C);
    add_write(REG_LOWER_LIMIT, 32'd100);
    add_write(REG_GAIN, 32'h0000_0100);
    add_tick(16'd19, 32'd0, 32'd50);
    add_tick(16'd20, 32'd0, 32'hFFFF_FE0C);
    // disabled overrides position mode
    add_write(REG_RUN_ENABLE, 32'd0);
    add_tick(16'd1234, 32'd5678, 32'd90000, 1'b1, 16'd0, DIR_FWD);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_tick(dir_rows[i].tick, dir_rows[i].typed,
                  dir_rows[i].want_duty, dir_rows[i].want_dir);
      end
    end

    run_random(280, 14, 86);
    run_random(280, 86, 14);
    run_random(280, 0, 0);
    drain_pipe();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hang guard: far above the slowest legal run, ends with a failure.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
